[hdl/pafb_pkg.sv]
`default_nettype none

package pafb_pkg;

   // field and datapath widths
   localparam int FIELD_W         = 32;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int NORM_W          = 31;
   localparam int LEN2_W          = 64;
   localparam int ROOT_W          = 32;
   localparam int REM_W           = 36;
   localparam int QUO_W           = 31;
   localparam int DREM_W          = 34;
   localparam int VV_W            = 99;
   localparam int XPROD_W         = 64;
   localparam int SKID_DEPTH      = 2;

   // running state of one square root cell
   typedef struct packed {
      logic [LEN2_W-1:0] rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_st_type;

   // running state of one divider cell, three lanes sharing one divisor
   typedef struct packed {
      logic [ROOT_W-1:0]            len;
      logic [2:0][DREM_W-1:0]       rem;
      logic [2:0][QUO_W-1:0]        quo;
   } div_st_type;

   // one finished frame
   typedef struct packed {
      logic [2:0][FIELD_W-1:0] u;
      logic [2:0][FIELD_W-1:0] v;
      logic [2:0][FIELD_W-1:0] w;
      logic                    status;
   } frame_type;

   // stages of one normaliser, in order: magnitude, shifter, square, sum, root, divide, sign
   function automatic int unit_lat(input int vw);
      return $clog2(vw) + 4 + ROOT_W + QUO_W;
   endfunction

endpackage

`default_nettype wire

[hdl/plane_aligned_frame_builder.sv]
// channel  | ports        | handshake          | carries
// req      | req_*        | req_valid/req_stall | plane a..d, two reference points
// rsp      | rsp_*        | rsp_valid/rsp_stall | u, v, w unit axes and status
//
// One transaction enters per cycle while req_stall is low; the pipeline depth is set by the
// two row-of-cells normalisers (32 square root cells and 31 divider cells each) in series.
// Reset clears only the valid chain and the output buffer count; payload is not reset.
// A two-entry output buffer lets the pipeline keep moving while one result waits.
// req_stall rises only when that buffer is full and a result sits at the pipeline end.
`default_nettype none

module plane_aligned_frame_builder #(
   parameter int COORD_WIDTH = pafb_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_plane_a,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_plane_b,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_plane_c,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_plane_d,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_first_point_x,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_first_point_y,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_first_point_z,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_second_point_x,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_second_point_y,
   input  logic signed [pafb_pkg::FIELD_W-1:0]  req_second_point_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_u_x,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_u_y,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_u_z,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_v_x,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_v_y,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_v_z,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_w_x,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_w_y,
   output logic signed [pafb_pkg::FIELD_W-1:0]  rsp_axis_w_z,
   output logic                                 rsp_status
);
   import pafb_pkg::*;

   localparam int SEXT_W  = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
   localparam int SEXT_SH = FIELD_W - SEXT_W;
   localparam int PRE     = 6;
   localparam int LAT_V   = unit_lat(VV_W);
   localparam int LAT_U   = unit_lat(XPROD_W);
   localparam int TOTAL   = PRE + LAT_V + 2 + LAT_U;
   localparam int PROD_W  = 2 * FIELD_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int LO_W    = 33;
   localparam int HI_W    = DOT_W - LO_W;
   localparam int PA_W    = VV_W - 1;
   localparam int CNT_W   = $clog2(SKID_DEPTH + 1);
   localparam int HOLD_W  = 1 + 6 * FIELD_W;

   // pipeline control
   logic                 advance;
   logic                 accept;
   logic [TOTAL-1:0]     valid_ff;
   logic [TOTAL-1:0]     valid_in;
   logic                 push;
   logic                 pop;

   // input capture
   logic signed [FIELD_W-1:0] n0_ff  [3];
   logic signed [FIELD_W-1:0] p1_0_ff[3];
   logic signed [FIELD_W-1:0] p2_0_ff[3];
   logic signed [FIELD_W-1:0] d0_ff;

   // dot product terms
   logic signed [PROD_W-1:0]  m1_ff  [3];
   logic signed [PROD_W-1:0]  m2_ff  [3];
   logic signed [FIELD_W-1:0] p1_1_ff[3];
   logic signed [FIELD_W-1:0] p2_1_ff[3];
   logic                      dneg1_ff;
   logic                      dzero1_ff;

   logic signed [DOT_W-1:0]   dot1_ff;
   logic signed [DOT_W-1:0]   dot2_ff;
   logic signed [FIELD_W-1:0] p1_2_ff[3];
   logic signed [FIELD_W-1:0] p2_2_ff[3];
   logic                      dneg2_ff;
   logic                      dzero2_ff;

   // split wide products
   logic signed [LO_W:0]              dot1_lo;
   logic signed [LO_W:0]              dot2_lo;
   logic signed [HI_W-1:0]            dot1_hi;
   logic signed [HI_W-1:0]            dot2_hi;
   logic signed [LO_W+FIELD_W:0]      plo1_ff[3];
   logic signed [LO_W+FIELD_W:0]      plo2_ff[3];
   logic signed [HI_W+FIELD_W-1:0]    phi1_ff[3];
   logic signed [HI_W+FIELD_W-1:0]    phi2_ff[3];
   logic                              deg3_ff;
   logic                              flip3_ff;

   logic signed [PA_W-1:0]    pa_ff[3];
   logic signed [PA_W-1:0]    pb_ff[3];
   logic                      deg4_ff;
   logic                      flip4_ff;

   logic [2:0][VV_W-1:0]      vv5_ff;
   logic                      deg5_ff;

   // normalisers and their side lines
   logic [3*FIELD_W-1:0]      n_late;
   logic [2:0][VV_W-1:0]      w_vec;
   logic [2:0][FIELD_W-1:0]   uw_out;
   logic [2:0][FIELD_W-1:0]   uv_out;
   logic                      zero_w;
   logic                      zero_v;
   logic                      deg_late;

   logic signed [PROD_W-1:0]  xp6_ff[6];
   logic                      ok6_ff;
   logic [2:0][FIELD_W-1:0]   uv6_ff;
   logic [2:0][FIELD_W-1:0]   uw6_ff;
   logic                      ok6_in;

   logic [2:0][XPROD_W-1:0]   xv7_ff;
   logic                      ok7_ff;
   logic [2:0][FIELD_W-1:0]   uv7_ff;
   logic [2:0][FIELD_W-1:0]   uw7_ff;

   logic [HOLD_W-1:0]         hold_late;
   logic [2:0][FIELD_W-1:0]   uu_out;
   logic                      zero_u;
   logic                      ok_end;
   frame_type                 frame_end;

   // output buffer
   frame_type                 head_ff;
   frame_type                 tail_ff;
   frame_type                 head_in;
   frame_type                 tail_in;
   logic [CNT_W-1:0]          cnt_ff;
   logic [CNT_W-1:0]          cnt_in;

   // the whole pipeline moves unless the buffer is full and a result is waiting
   assign advance   = !((cnt_ff == CNT_W'(SKID_DEPTH)) && valid_ff[TOTAL-1]);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign push      = advance && valid_ff[TOTAL-1];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      valid_in = {valid_ff[TOTAL-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // capture with sign extension of the point and offset fields
   always_ff @(posedge clock) begin
      if (advance) begin
         n0_ff[0]   <= req_plane_a;
         n0_ff[1]   <= req_plane_b;
         n0_ff[2]   <= req_plane_c;
         d0_ff      <= (req_plane_d <<< SEXT_SH) >>> SEXT_SH;
         p1_0_ff[0] <= (req_first_point_x <<< SEXT_SH) >>> SEXT_SH;
         p1_0_ff[1] <= (req_first_point_y <<< SEXT_SH) >>> SEXT_SH;
         p1_0_ff[2] <= (req_first_point_z <<< SEXT_SH) >>> SEXT_SH;
         p2_0_ff[0] <= (req_second_point_x <<< SEXT_SH) >>> SEXT_SH;
         p2_0_ff[1] <= (req_second_point_y <<< SEXT_SH) >>> SEXT_SH;
         p2_0_ff[2] <= (req_second_point_z <<< SEXT_SH) >>> SEXT_SH;
      end
   end

   // halves of the two divisors for the narrow multipliers
   always_comb begin
      dot1_lo = $signed({1'b0, dot1_ff[LO_W-1:0]});
      dot2_lo = $signed({1'b0, dot2_ff[LO_W-1:0]});
      dot1_hi = dot1_ff[DOT_W-1:LO_W];
      dot2_hi = dot2_ff[DOT_W-1:LO_W];
   end

   // divisors, direction difference p2*D1 - p1*D2 and the sign flip
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            m1_ff[i]   <= n0_ff[i] * p1_0_ff[i];
            m2_ff[i]   <= n0_ff[i] * p2_0_ff[i];
            p1_1_ff[i] <= p1_0_ff[i];
            p2_1_ff[i] <= p2_0_ff[i];
            p1_2_ff[i] <= p1_1_ff[i];
            p2_2_ff[i] <= p2_1_ff[i];
            plo1_ff[i] <= dot1_lo * p2_2_ff[i];
            phi1_ff[i] <= dot1_hi * p2_2_ff[i];
            plo2_ff[i] <= dot2_lo * p1_2_ff[i];
            phi2_ff[i] <= dot2_hi * p1_2_ff[i];
            pa_ff[i]   <= (PA_W'(phi1_ff[i]) <<< LO_W) + PA_W'(plo1_ff[i]);
            pb_ff[i]   <= (PA_W'(phi2_ff[i]) <<< LO_W) + PA_W'(plo2_ff[i]);
            vv5_ff[i]  <= flip4_ff ? VV_W'(VV_W'(pb_ff[i]) - VV_W'(pa_ff[i]))
                                   : VV_W'(VV_W'(pa_ff[i]) - VV_W'(pb_ff[i]));
         end
         dneg1_ff  <= d0_ff[FIELD_W-1];
         dzero1_ff <= (d0_ff == '0);
         dot1_ff   <= DOT_W'(m1_ff[0]) + DOT_W'(m1_ff[1]) + DOT_W'(m1_ff[2]);
         dot2_ff   <= DOT_W'(m2_ff[0]) + DOT_W'(m2_ff[1]) + DOT_W'(m2_ff[2]);
         dneg2_ff  <= dneg1_ff;
         dzero2_ff <= dzero1_ff;
         deg3_ff   <= (dot1_ff == '0) || (dot2_ff == '0) || dzero2_ff;
         flip3_ff  <= ((!dneg2_ff && !dzero2_ff) != dot1_ff[DOT_W-1]) != dot2_ff[DOT_W-1];
         deg4_ff   <= deg3_ff;
         flip4_ff  <= flip3_ff;
         deg5_ff   <= deg4_ff;
      end
   end

   // normal coefficients follow the difference path to the normalisers
   pafb_delay #(
      .WIDTH (3 * FIELD_W),
      .DEPTH (PRE - 1)
   ) u_normal_line (
      .clock    (clock),
      .enable   (advance),
      .data_in  ({n0_ff[2], n0_ff[1], n0_ff[0]}),
      .data_out (n_late)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w_vec[i] = VV_W'($signed(n_late[i*FIELD_W +: FIELD_W]));
      end
   end

   pafb_unit3 #(
      .VW (VV_W)
   ) u_norm_w (
      .clock    (clock),
      .enable   (advance),
      .vec_in   (w_vec),
      .unit_out (uw_out),
      .zero_out (zero_w)
   );

   pafb_unit3 #(
      .VW (VV_W)
   ) u_norm_v (
      .clock    (clock),
      .enable   (advance),
      .vec_in   (vv5_ff),
      .unit_out (uv_out),
      .zero_out (zero_v)
   );

   pafb_delay #(
      .WIDTH (1),
      .DEPTH (LAT_V)
   ) u_deg_line (
      .clock    (clock),
      .enable   (advance),
      .data_in  (deg5_ff),
      .data_out (deg_late)
   );

   // cross product v x w
   assign ok6_in = !deg_late && !zero_v && !zero_w;

   always_ff @(posedge clock) begin
      if (advance) begin
         xp6_ff[0] <= $signed(uv_out[1]) * $signed(uw_out[2]);
         xp6_ff[1] <= $signed(uv_out[2]) * $signed(uw_out[1]);
         xp6_ff[2] <= $signed(uv_out[2]) * $signed(uw_out[0]);
         xp6_ff[3] <= $signed(uv_out[0]) * $signed(uw_out[2]);
         xp6_ff[4] <= $signed(uv_out[0]) * $signed(uw_out[1]);
         xp6_ff[5] <= $signed(uv_out[1]) * $signed(uw_out[0]);
         ok6_ff    <= ok6_in;
         uv6_ff    <= uv_out;
         uw6_ff    <= uw_out;
         for (int i = 0; i < 3; i++) begin
            xv7_ff[i] <= XPROD_W'(xp6_ff[2*i] - xp6_ff[2*i+1]);
         end
         ok7_ff    <= ok6_ff;
         uv7_ff    <= uv6_ff;
         uw7_ff    <= uw6_ff;
      end
   end

   pafb_unit3 #(
      .VW (XPROD_W)
   ) u_norm_u (
      .clock    (clock),
      .enable   (advance),
      .vec_in   (xv7_ff),
      .unit_out (uu_out),
      .zero_out (zero_u)
   );

   pafb_delay #(
      .WIDTH (HOLD_W),
      .DEPTH (LAT_U)
   ) u_hold_line (
      .clock    (clock),
      .enable   (advance),
      .data_in  ({ok7_ff, uv7_ff, uw7_ff}),
      .data_out (hold_late)
   );

   // final frame, zeroed when degenerate
   always_comb begin
      ok_end           = hold_late[HOLD_W-1] && !zero_u;
      frame_end.u      = ok_end ? uu_out : '0;
      frame_end.v      = ok_end ? hold_late[6*FIELD_W-1 -: 3*FIELD_W] : '0;
      frame_end.w      = ok_end ? hold_late[3*FIELD_W-1:0] : '0;
      frame_end.status = !ok_end;
   end

   // two-entry output buffer
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == '0) begin
               head_in = frame_end;
            end else begin
               tail_in = frame_end;
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         2'b01: begin
            head_in = tail_ff;
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         2'b11: begin
            if (cnt_ff == CNT_W'(1)) begin
               head_in = frame_end;
            end else begin
               head_in = tail_ff;
               tail_in = frame_end;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_valid    = (cnt_ff != '0);
   assign rsp_axis_u_x = head_ff.u[0];
   assign rsp_axis_u_y = head_ff.u[1];
   assign rsp_axis_u_z = head_ff.u[2];
   assign rsp_axis_v_x = head_ff.v[0];
   assign rsp_axis_v_y = head_ff.v[1];
   assign rsp_axis_v_z = head_ff.v[2];
   assign rsp_axis_w_x = head_ff.w[0];
   assign rsp_axis_w_y = head_ff.w[1];
   assign rsp_axis_w_z = head_ff.w[2];
   assign rsp_status   = head_ff.status;

   // buffer never overfills
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SKID_DEPTH))
      else $error("output buffer count out of range");

   // a degenerate transaction carries all-zero axes
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
         (rsp_axis_u_x == '0 && rsp_axis_u_y == '0 && rsp_axis_u_z == '0 &&
          rsp_axis_v_x == '0 && rsp_axis_v_y == '0 && rsp_axis_v_z == '0 &&
          rsp_axis_w_x == '0 && rsp_axis_w_y == '0 && rsp_axis_w_z == '0))
      else $error("degenerate frame with nonzero axis");

   // stall only when the buffer is full and a result waits at the end
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (cnt_ff == CNT_W'(SKID_DEPTH) && valid_ff[TOTAL-1]))
      else $error("input stalled without a full output buffer");

   // a taken result from a full buffer frees the pipeline next cycle
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_W'(SKID_DEPTH) && pop) |=> !req_stall)
      else $error("pipeline still held after output buffer drained");

endmodule

`default_nettype wire

[hdl/pafb_delay.sv]
`default_nettype none

module pafb_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift line, one tap per cycle while enable is high
   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= data_in;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

[hdl/pafb_sqrt_cell.sv]
`default_nettype none

module pafb_sqrt_cell #(
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  enable,
   input  pafb_pkg::sqrt_st_type up_st,
   input  logic [SIDE_W-1:0]     up_side,
   output pafb_pkg::sqrt_st_type dn_st,
   output logic [SIDE_W-1:0]     dn_side
);
   import pafb_pkg::*;

   sqrt_st_type       st_in;
   sqrt_st_type       st_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              fits;

   // one root bit: bring down two radicand bits, try 4*root+1
   always_comb begin
      rem_sh      = {up_st.rem[REM_W-3:0], up_st.rad[LEN2_W-1 -: 2]};
      trial       = REM_W'({up_st.root, 2'b01});
      fits        = (rem_sh >= trial);
      st_in.rad   = up_st.rad << 2;
      st_in.rem   = fits ? (rem_sh - trial) : rem_sh;
      st_in.root  = {up_st.root[ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff   <= st_in;
         side_ff <= up_side;
      end
   end

   assign dn_st   = st_ff;
   assign dn_side = side_ff;

endmodule

`default_nettype wire

[hdl/pafb_div_cell.sv]
`default_nettype none

module pafb_div_cell #(
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 enable,
   input  pafb_pkg::div_st_type up_st,
   input  logic [SIDE_W-1:0]    up_side,
   output pafb_pkg::div_st_type dn_st,
   output logic [SIDE_W-1:0]    dn_side
);
   import pafb_pkg::*;

   div_st_type             st_in;
   div_st_type             st_ff;
   logic [SIDE_W-1:0]      side_ff;
   logic [2:0]             fits;
   logic [2:0][DREM_W-1:0] kept;

   // one restoring quotient bit for each lane
   always_comb begin
      st_in.len = up_st.len;
      for (int i = 0; i < 3; i++) begin
         fits[i]      = (up_st.rem[i] >= DREM_W'(up_st.len));
         kept[i]      = fits[i] ? (up_st.rem[i] - DREM_W'(up_st.len)) : up_st.rem[i];
         st_in.rem[i] = kept[i] << 1;
         st_in.quo[i] = {up_st.quo[i][QUO_W-2:0], fits[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff   <= st_in;
         side_ff <= up_side;
      end
   end

   assign dn_st   = st_ff;
   assign dn_side = side_ff;

endmodule

`default_nettype wire

[hdl/pafb_unit3.sv]
`default_nettype none

module pafb_unit3 #(
   parameter int VW = 64
) (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [2:0][VW-1:0]               vec_in,
   output logic [2:0][pafb_pkg::FIELD_W-1:0] unit_out,
   output logic                             zero_out
);
   import pafb_pkg::*;

   localparam int NSH  = $clog2(VW);
   localparam int SQ_W = 2 * NORM_W;

   typedef struct packed {
      logic [2:0][NORM_W-1:0] mag;
      logic [2:0]             neg;
      logic                   zero;
   } root_side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } div_side_type;

   logic [2:0][VW-1:0]       mag_in;
   logic [NSH:0][2:0][VW-1:0] nmag_ff;
   logic [NSH:0][2:0]        neg_ff;
   logic [NSH:0]             zero_ff;
   logic [NSH-1:0][VW-1:0]   any_w;
   logic [NSH-1:0]           lead_clear;
   logic [2:0][NORM_W-1:0]   top_w;
   logic [2:0][NORM_W-1:0]   sq_mag_ff;
   logic [2:0][SQ_W-1:0]     sq_ff;
   logic [2:0]               sq_neg_ff;
   logic                     sq_zero_ff;
   logic [LEN2_W-1:0]        len2_ff;
   root_side_type            sum_side_ff;
   sqrt_st_type              root_st   [ROOT_W+1];
   root_side_type            root_side [ROOT_W+1];
   div_st_type               div_st    [QUO_W+1];
   div_side_type             div_side  [QUO_W+1];
   logic [2:0][FIELD_W-1:0]  unit_in;
   logic [2:0][FIELD_W-1:0]  unit_ff;
   logic                     zero_out_ff;

   // magnitudes of the three components
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = vec_in[i][VW-1] ? ((~vec_in[i]) + VW'(1)) : vec_in[i];
      end
   end

   // leading zero test for each shifter stage, on the or of all three words
   always_comb begin
      for (int s = 0; s < NSH; s++) begin
         any_w[s]      = nmag_ff[s][0] | nmag_ff[s][1] | nmag_ff[s][2];
         lead_clear[s] = ((any_w[s] >> (VW - (1 << (NSH - 1 - s)))) == '0);
      end
      for (int i = 0; i < 3; i++) begin
         top_w[i] = nmag_ff[NSH][i][VW-1 -: NORM_W];
      end
   end

   // magnitude, normalising shifter, squares, sum of squares and the output registers
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            nmag_ff[0][i] <= mag_in[i];
            neg_ff[0][i]  <= vec_in[i][VW-1];
         end
         zero_ff[0] <= (vec_in == '0);
         for (int s = 0; s < NSH; s++) begin
            for (int i = 0; i < 3; i++) begin
               nmag_ff[s+1][i] <= lead_clear[s] ?
                                  (nmag_ff[s][i] << (1 << (NSH - 1 - s))) : nmag_ff[s][i];
            end
            neg_ff[s+1]  <= neg_ff[s];
            zero_ff[s+1] <= zero_ff[s];
         end
         for (int i = 0; i < 3; i++) begin
            sq_mag_ff[i] <= top_w[i];
            sq_ff[i]     <= top_w[i] * top_w[i];
         end
         sq_neg_ff        <= neg_ff[NSH];
         sq_zero_ff       <= zero_ff[NSH];
         len2_ff          <= LEN2_W'(sq_ff[0]) + LEN2_W'(sq_ff[1]) + LEN2_W'(sq_ff[2]);
         sum_side_ff.mag  <= sq_mag_ff;
         sum_side_ff.neg  <= sq_neg_ff;
         sum_side_ff.zero <= sq_zero_ff;
         unit_ff          <= unit_in;
         zero_out_ff      <= div_side[QUO_W].zero;
      end
   end

   // square root row, one root bit per cell
   always_comb begin
      root_st[0].rad  = len2_ff;
      root_st[0].rem  = '0;
      root_st[0].root = '0;
      root_side[0]    = sum_side_ff;
   end

   for (genvar j = 0; j < ROOT_W; j++) begin : g_root
      pafb_sqrt_cell #(
         .SIDE_W ($bits(root_side_type))
      ) u_cell (
         .clock   (clock),
         .enable  (enable),
         .up_st   (root_st[j]),
         .up_side (root_side[j]),
         .dn_st   (root_st[j+1]),
         .dn_side (root_side[j+1])
      );
   end

   // divider row, one quotient bit per cell
   always_comb begin
      div_st[0].len = root_st[ROOT_W].root;
      for (int i = 0; i < 3; i++) begin
         div_st[0].rem[i] = DREM_W'(root_side[ROOT_W].mag[i]);
         div_st[0].quo[i] = '0;
      end
      div_side[0].neg  = root_side[ROOT_W].neg;
      div_side[0].zero = root_side[ROOT_W].zero;
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      pafb_div_cell #(
         .SIDE_W ($bits(div_side_type))
      ) u_cell (
         .clock   (clock),
         .enable  (enable),
         .up_st   (div_st[j]),
         .up_side (div_side[j]),
         .dn_st   (div_st[j+1]),
         .dn_side (div_side[j+1])
      );
   end

   // restore the signs
   always_comb begin
      logic [FIELD_W-1:0] qext;
      for (int i = 0; i < 3; i++) begin
         qext       = FIELD_W'(div_st[QUO_W].quo[i]);
         unit_in[i] = div_side[QUO_W].neg[i] ? ((~qext) + FIELD_W'(1)) : qext;
      end
   end

   assign unit_out = unit_ff;
   assign zero_out = zero_out_ff;

endmodule

`default_nettype wire
